>>> hdl/frustum_sphere_cull_defines.svh
// Assertion macros shared by the culling block.
`ifndef FRUSTUM_SPHERE_CULL_DEFINES_SVH
`define FRUSTUM_SPHERE_CULL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fsc_pkg.sv
package fsc_pkg;

    localparam int NUM_PLANES       = 6;
    localparam int FIRST_SIDE_PLANE = 2;
    localparam int NORMAL_FRAC_BITS = 16;
    localparam int COORD_FRAC_BITS  = 16;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 3;
    localparam int NORMAL_W = 18;
    localparam int OFFSET_W = 32;
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;

    // One product n*c, and offset plus radius before scaling
    localparam int PROD_W = NORMAL_W + COORD_W;
    localparam int DR_W   = OFFSET_W + 1;
    // Full distance plus scaled radius, exact
    localparam int SUM_W  = PROD_W + 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD       = 2'd0,
        CMD_TEST_ALL   = 2'd1,
        CMD_TEST_SIDES = 2'd2
    } t_cmd;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] nz;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nx;
        logic signed [OFFSET_W-1:0] offset;
    } t_plane;

    // Pipeline control shared with the per-plane units
    typedef struct packed {
        logic s2_en;
    } t_pipe_ctl;

endpackage

>>> hdl/fsc_plane_test.sv
// One plane: register the three products and offset+radius, then sign-test the sum.
module fsc_plane_test (
    input  logic                                   i_clk,
    input  fsc_pkg::t_pipe_ctl                     i_ctl,
    input  fsc_pkg::t_plane                        i_plane,
    input  logic signed [fsc_pkg::COORD_W-1:0]     i_center_x,
    input  logic signed [fsc_pkg::COORD_W-1:0]     i_center_y,
    input  logic signed [fsc_pkg::COORD_W-1:0]     i_center_z,
    input  logic        [fsc_pkg::RADIUS_W-1:0]    i_radius,
    output logic                                   o_reach
);

    logic signed [fsc_pkg::PROD_W-1:0] n_px, n_py, n_pz;
    logic signed [fsc_pkg::PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [fsc_pkg::DR_W-1:0]   n_dr, r_dr;
    logic signed [fsc_pkg::SUM_W-1:0]  n_sum;

    // Multiply normal by center, add radius to offset
    always_comb begin
        n_px = $signed(i_plane.nx) * $signed(i_center_x);
        n_py = $signed(i_plane.ny) * $signed(i_center_y);
        n_pz = $signed(i_plane.nz) * $signed(i_center_z);
        n_dr = fsc_pkg::DR_W'(i_plane.offset) + $signed({2'b00, i_radius});
    end

    // Hold products for the summing stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
            r_dr <= n_dr;
        end
    end

    // Bring offset+radius to the product format and sum exactly
    always_comb begin
        n_sum = fsc_pkg::SUM_W'(r_px) + fsc_pkg::SUM_W'(r_py) + fsc_pkg::SUM_W'(r_pz)
              + fsc_pkg::SUM_W'($signed({r_dr, {fsc_pkg::NORMAL_FRAC_BITS{1'b0}}}));
        o_reach = !n_sum[fsc_pkg::SUM_W-1];
    end

endmodule

>>> hdl/frustum_sphere_cull.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: plane, normals, offset, center, radius
//                                          tuser: command
// m_axis    out  m_axis_tvalid/tready      tdata: touches
//
// Each item passes the input register, the product register (18x32 multipliers,
// three per plane, six planes in parallel), and the result register after the 53-bit sum.
// One item is accepted per cycle while the result side keeps up; each stage moves
// on as soon as the one after it is empty or advancing, so bubbles fill under stall.
// Reset (synchronous, active low) empties the pipeline and clears all six planes.
// A load writes its plane at acceptance; tests accepted after it see the new plane.
`include "frustum_sphere_cull_defines.svh"

module frustum_sphere_cull (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] plane_index, [20:3] normal_x, [38:21] normal_y, [56:39] normal_z,
    // [88:57] plane_offset, [120:89] center_x, [152:121] center_y,
    // [184:153] center_z, [215:185] radius
    input  logic [215:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] touches, [7:1] zero
    output logic [7:0]   m_axis_tdata
);

    // Unpack input fields
    logic [fsc_pkg::IDX_W-1:0]           in_idx;
    fsc_pkg::t_plane                     in_plane;
    logic signed [fsc_pkg::COORD_W-1:0]  in_cx, in_cy, in_cz;
    logic [fsc_pkg::RADIUS_W-1:0]        in_r;
    fsc_pkg::t_cmd                       in_cmd;

    assign in_idx          = s_axis_tdata[2:0];
    assign in_plane.nx     = s_axis_tdata[20:3];
    assign in_plane.ny     = s_axis_tdata[38:21];
    assign in_plane.nz     = s_axis_tdata[56:39];
    assign in_plane.offset = s_axis_tdata[88:57];
    assign in_cx           = s_axis_tdata[120:89];
    assign in_cy           = s_axis_tdata[152:121];
    assign in_cz           = s_axis_tdata[184:153];
    assign in_r            = s_axis_tdata[215:185];
    assign in_cmd          = fsc_pkg::t_cmd'(s_axis_tuser);

    logic                                r_s1_valid, r_s2_valid, r_out_valid;
    fsc_pkg::t_cmd                       r_s1_cmd, r_s2_cmd;
    logic signed [fsc_pkg::COORD_W-1:0]  r_s1_cx, r_s1_cy, r_s1_cz;
    logic [fsc_pkg::RADIUS_W-1:0]        r_s1_r;
    logic                                r_touches, n_touches;
    fsc_pkg::t_plane                     r_planes [fsc_pkg::NUM_PLANES];
    logic [fsc_pkg::NUM_PLANES-1:0]      reach;
    logic                                out_ready, s2_ready, s1_ready, in_accept, load_wr;
    logic                                load_drop, s2_load_out;
    fsc_pkg::t_pipe_ctl                  ctl;

    // Per-stage ready: a stage takes new data when empty or draining
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s2_ready      = !r_s2_valid || out_ready;
    assign s1_ready      = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_accept     = s_axis_tvalid && s1_ready;
    assign ctl.s2_en     = s2_ready;

    assign load_wr = in_accept && (in_cmd == fsc_pkg::CMD_LOAD)
                     && (in_idx < fsc_pkg::IDX_W'(fsc_pkg::NUM_PLANES));

    // Flag loads that hit a missing slot and loads leaving the product stage
    assign load_drop   = in_accept && (in_cmd == fsc_pkg::CMD_LOAD)
                         && !(in_idx < fsc_pkg::IDX_W'(fsc_pkg::NUM_PLANES));
    assign s2_load_out = r_s2_valid && out_ready && (r_s2_cmd == fsc_pkg::CMD_LOAD);

    // Write the plane table; drop loads to slots past the last plane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fsc_pkg::NUM_PLANES; k++) begin
                r_planes[k] <= '0;
            end
        end else if (load_wr) begin
            r_planes[in_idx] <= in_plane;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= in_cmd;
            r_s1_cx  <= in_cx;
            r_s1_cy  <= in_cy;
            r_s1_cz  <= in_cz;
            r_s1_r   <= in_r;
        end
        if (s2_ready) begin
            r_s2_cmd <= r_s1_cmd;
        end
        if (out_ready) begin
            r_touches <= n_touches;
        end
    end

    // Distance test against each plane
    for (genvar g = 0; g < fsc_pkg::NUM_PLANES; g++) begin : g_plane
        fsc_plane_test u_plane (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_plane    (r_planes[g]),
            .i_center_x (r_s1_cx),
            .i_center_y (r_s1_cy),
            .i_center_z (r_s1_cz),
            .i_radius   (r_s1_r),
            .o_reach    (reach[g])
        );
    end

    // Combine the selected planes; loads and unused commands answer zero
    always_comb begin
        n_touches = 1'b0;
        unique case (r_s2_cmd)
            fsc_pkg::CMD_TEST_ALL: begin
                n_touches = &reach;
            end
            fsc_pkg::CMD_TEST_SIDES: begin
                n_touches = 1'b1;
                for (int k = fsc_pkg::FIRST_SIDE_PLANE; k < fsc_pkg::NUM_PLANES; k++) begin
                    if (!reach[k]) begin
                        n_touches = 1'b0;
                    end
                end
            end
            default: begin
                n_touches = 1'b0;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_touches};

    `FSC_ASSERT_NEXT(a_load_writes, load_wr, r_planes[$past(in_idx)] == $past(in_plane), "lost load")
    `FSC_ASSERT_NEXT(a_bad_slot_keeps, load_drop, $stable(r_planes[0]) && $stable(r_planes[5]), "bad load")
    `FSC_ASSERT_NEXT(a_load_zero, s2_load_out, m_axis_tvalid && !m_axis_tdata[0], "load answered one")
    `FSC_ASSERT_NEXT(a_s1_moves, r_s1_valid && s2_ready, r_s2_valid, "stage one item lost")
    `FSC_ASSERT_NOW(a_no_overrun, in_accept && r_s1_valid, s2_ready, "stage one overwritten")

endmodule
